/* src/wsts_pkg.sv */
// Package for the weighted sum tree selector: field widths, request and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
package wsts_pkg;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 10;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 42;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int LEAVES_DEF = 1024;
    localparam logic [COUNT_W-1:0] LEAF_COUNT_RST = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request fields
        logic clear;     // write one zero entry of the clearing pass
        logic eval;      // check request, start assign or descent
        logic desc;      // one level of the descent
        logic up;        // one level of the ancestor update
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic eval_assign;
        logic eval_lookup;
        logic desc_leaf;
        logic is_remove;
        logic up_root;
    } stat_t;

endpackage

/* src/wsts_datapath.sv */
// Datapath: node sum memory, descent and ancestor-update arithmetic,
// request and result registers, leaf_count register. Depends on wsts_pkg.
module wsts_datapath #(
    parameter int LEAVES = wsts_pkg::LEAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wsts_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic [wsts_pkg::FUNC_W-1:0]   func,
    input  logic [wsts_pkg::IDX_W-1:0]    leaf_index,
    input  logic [wsts_pkg::WEIGHT_W-1:0] weight,
    input  logic [wsts_pkg::SUM_W-1:0]    target,
    input  wsts_pkg::cmd_t                cmd,
    output wsts_pkg::stat_t               stat,
    output logic [wsts_pkg::IDX_W-1:0]    found_leaf,
    output logic [wsts_pkg::WEIGHT_W-1:0] remainder,
    output logic [wsts_pkg::SUM_W-1:0]    total_weight,
    output logic [wsts_pkg::STATUS_W-1:0] status
);

    localparam int NODES = 2 * LEAVES - 1;
    localparam int NW    = $clog2(NODES);
    localparam logic [NW-1:0] FIRST_LEAF_N = NW'(LEAVES - 1);
    localparam logic [NW-1:0] LAST_NODE_N  = NW'(NODES - 1);

    logic [wsts_pkg::SUM_W-1:0] mem [NODES];

    logic [wsts_pkg::FUNC_W-1:0]   func_reg;
    logic [wsts_pkg::IDX_W-1:0]    idx_reg;
    logic [wsts_pkg::WEIGHT_W-1:0] weight_reg;
    logic [wsts_pkg::SUM_W-1:0]    target_reg;
    logic [NW-1:0]                 node_reg;
    logic [wsts_pkg::SUM_W-1:0]    x_reg;
    logic [wsts_pkg::SUM_W-1:0]    acc_reg;
    logic [wsts_pkg::SUM_W-1:0]    total_reg;
    logic [wsts_pkg::SUM_W-1:0]    rdata_reg;
    logic [wsts_pkg::IDX_W-1:0]    found_reg;
    logic [wsts_pkg::WEIGHT_W-1:0] rem_reg;
    logic [wsts_pkg::STATUS_W-1:0] status_reg;
    logic [wsts_pkg::COUNT_W-1:0]  leaf_count_reg;

    logic                          mem_we;
    logic [NW-1:0]                 mem_waddr;
    logic [wsts_pkg::SUM_W-1:0]    mem_wdata;
    logic [NW-1:0]                 mem_raddr;

    logic [NW-1:0]                 left_n;
    logic [NW-1:0]                 next_n;
    logic [NW-1:0]                 parent_n;
    logic [NW-1:0]                 leaf_n;
    logic                          go_left;
    logic [wsts_pkg::SUM_W-1:0]    x_desc;
    logic [wsts_pkg::SUM_W-1:0]    up_sum;
    logic                          is_lookup;
    logic                          range_err;
    logic                          above_err;
    logic                          assign_ok;
    logic                          lookup_ok;
    logic                          desc_leaf;
    logic                          up_root;

    function automatic logic [NW-1:0] sibling(input logic [NW-1:0] n);
        return n[0] ? n + NW'(1) : n - NW'(1);
    endfunction

    // descent: rdata_reg holds the left child sum of node_reg
    assign left_n   = NW'({node_reg, 1'b1});
    assign go_left  = x_reg < rdata_reg;
    assign next_n   = go_left ? left_n : left_n + NW'(1);
    assign x_desc   = go_left ? x_reg : x_reg - rdata_reg;
    assign desc_leaf = next_n >= FIRST_LEAF_N;

    // ancestor update: rdata_reg holds the sibling sum of node_reg
    assign parent_n = (node_reg - NW'(1)) >> 1;
    assign up_sum   = acc_reg + rdata_reg;
    assign up_root  = parent_n == '0;

    assign leaf_n    = NW'(idx_reg) + FIRST_LEAF_N;
    assign is_lookup = func_reg == wsts_pkg::FUNC_LOOKUP || func_reg == wsts_pkg::FUNC_REMOVE;
    assign range_err = func_reg == wsts_pkg::FUNC_ASSIGN &&
                       ({1'b0, idx_reg} >= leaf_count_reg || 32'(idx_reg) >= LEAVES);
    assign above_err = is_lookup && target_reg > total_reg;
    assign assign_ok = func_reg == wsts_pkg::FUNC_ASSIGN && !range_err;
    assign lookup_ok = is_lookup && !above_err;

    assign stat.clear_last  = node_reg == LAST_NODE_N;
    assign stat.eval_assign = assign_ok;
    assign stat.eval_lookup = lookup_ok;
    assign stat.desc_leaf   = desc_leaf;
    assign stat.is_remove   = func_reg == wsts_pkg::FUNC_REMOVE;
    assign stat.up_root     = up_root;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = node_reg;
        mem_wdata = '0;
        mem_raddr = '0;
        if (cmd.clear)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.eval)
        begin
            if (assign_ok)
            begin
                mem_we    = 1'b1;
                mem_waddr = leaf_n;
                mem_wdata = wsts_pkg::SUM_W'(weight_reg);
                mem_raddr = sibling(leaf_n);
            end
            else if (lookup_ok)
            begin
                mem_raddr = NW'(1);
            end
        end
        else if (cmd.desc)
        begin
            if (!desc_leaf)
            begin
                mem_raddr = NW'({next_n, 1'b1});
            end
            else if (stat.is_remove)
            begin
                mem_we    = 1'b1;
                mem_waddr = next_n;
                mem_raddr = sibling(next_n);
            end
        end
        else if (cmd.up)
        begin
            mem_we    = 1'b1;
            mem_waddr = parent_n;
            mem_wdata = up_sum;
            if (!up_root)
            begin
                mem_raddr = sibling(parent_n);
            end
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg       <= '0;
            total_reg      <= '0;
            leaf_count_reg <= wsts_pkg::LEAF_COUNT_RST;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                leaf_count_reg <= cfg_wr_data;
            end
            if (cmd.clear)
            begin
                node_reg <= node_reg + NW'(1);
            end
            else if (cmd.eval)
            begin
                node_reg <= assign_ok ? leaf_n : '0;
            end
            else if (cmd.desc)
            begin
                node_reg <= next_n;
            end
            else if (cmd.up)
            begin
                node_reg <= parent_n;
                if (up_root)
                begin
                    total_reg <= up_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            idx_reg    <= leaf_index;
            weight_reg <= weight;
            target_reg <= target;
        end
        if (cmd.eval)
        begin
            acc_reg    <= wsts_pkg::SUM_W'(weight_reg);
            x_reg      <= target_reg;
            found_reg  <= '0;
            rem_reg    <= '0;
            status_reg <= range_err ? wsts_pkg::STATUS_RANGE :
                          above_err ? wsts_pkg::STATUS_ABOVE : wsts_pkg::STATUS_OK;
        end
        else if (cmd.desc)
        begin
            x_reg <= x_desc;
            if (desc_leaf)
            begin
                found_reg <= wsts_pkg::IDX_W'(next_n - FIRST_LEAF_N);
                rem_reg   <= wsts_pkg::WEIGHT_W'(x_desc);
                acc_reg   <= '0;
            end
        end
        else if (cmd.up)
        begin
            acc_reg <= up_sum;
        end
    end

    assign found_leaf   = found_reg;
    assign remainder    = rem_reg;
    assign total_weight = total_reg;
    assign status       = status_reg;

endmodule

/* src/wsts_ctrl.sv */
// Controller: sequences clearing pass, request check, descent levels,
// ancestor updates and the result strobe. Depends on wsts_pkg.
module wsts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  wsts_pkg::stat_t stat,
    output wsts_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_DESC  = 3'd3;
    localparam logic [2:0] ST_UP    = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (stat.eval_lookup)
                begin
                    state_next = ST_DESC;
                end
                else if (stat.eval_assign)
                begin
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DESC:
            begin
                cmd.desc = 1'b1;
                if (stat.desc_leaf)
                begin
                    state_next = stat.is_remove ? ST_UP : ST_DONE;
                end
            end
            ST_UP:
            begin
                cmd.up = 1'b1;
                if (stat.up_root)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;
    assign done = state_reg == ST_DONE;

endmodule

/* src/weighted_sum_tree_selector_core.sv */
// Weighted sum tree selector, top level: wsts_ctrl plus wsts_datapath.
// Accepted request: check, then a lookup descends one level per step to the leaf;
// an assign, or a remove after descent, updates ancestors level by level to the
// root; a rejected request goes straight to done. One memory access per level.
// One request at a time; next accepted the cycle after done. One read, one write port.
// Reset: async, clears control; a clearing pass then zeroes all node sums, busy high.
module weighted_sum_tree_selector_core #(
    parameter int LEAVES = wsts_pkg::LEAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request port
    input  logic                          start,
    output logic                          busy,
    input  logic [wsts_pkg::FUNC_W-1:0]   func,
    input  logic [wsts_pkg::IDX_W-1:0]    leaf_index,
    input  logic [wsts_pkg::WEIGHT_W-1:0] weight,
    input  logic [wsts_pkg::SUM_W-1:0]    target,
    // result port, valid for the one cycle done is high
    output logic                          done,
    output logic [wsts_pkg::IDX_W-1:0]    found_leaf,
    output logic [wsts_pkg::WEIGHT_W-1:0] remainder,
    output logic [wsts_pkg::SUM_W-1:0]    total_weight,
    output logic [wsts_pkg::STATUS_W-1:0] status,
    // leaf_count register write
    input  logic                          cfg_wr_en,
    input  logic [wsts_pkg::COUNT_W-1:0]  cfg_wr_data
);

    wsts_pkg::cmd_t  cmd;
    wsts_pkg::stat_t stat;

    // Controller owns sequencing only; the datapath owns all state of the tree.
    wsts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Node sums live in a heap-ordered memory; root sum also kept in a register
    // so the target check needs no memory read.
    wsts_datapath #(
        .LEAVES (LEAVES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .func         (func),
        .leaf_index   (leaf_index),
        .weight       (weight),
        .target       (target),
        .cmd          (cmd),
        .stat         (stat),
        .found_leaf   (found_leaf),
        .remainder    (remainder),
        .total_weight (total_weight),
        .status       (status)
    );

    // A result strobe returns the block to idle.
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("done not followed by idle");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Error results carry no leaf and no remainder.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != wsts_pkg::STATUS_OK) |-> (found_leaf == '0 && remainder == '0))
        else $error("error result with nonzero leaf or remainder");

    // The total only moves while a request is in work.
    a_total_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> $stable(total_weight))
        else $error("total changed while idle");

endmodule
